### hw/rtl/swm_pkg.sv
// Shared constants, types and helpers for the sliding window median filter.
`default_nettype none
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_BITS    = 7;
  localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int AGE_BITS    = $clog2(WINDOW_MAX);
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int WS_RESET    = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AGE_BITS-1:0]           age_t;
  typedef logic [CNT_BITS-1:0]           cnt_t;

  // Values every cell sees in the same cycle.
  typedef struct packed {
    sample_t samp;
    sample_t oldest;
    logic    full;
  } bcast_t;

  // Per-cell position flags derived from the current list length.
  typedef struct packed {
    logic in_b;
    logic in_bp;
    logic first;
  } cell_ctl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    sample_t val;
    age_t    age;
    logic    gt;
    logic    past;
  } cell_out_t;

endpackage
`default_nettype wire

### hw/rtl/sliding_window_median.sv
// Top level of the sliding window median filter: control, cell chain and result register.
`default_nettype none
// The filter takes one signed sample per clock and, once window_size samples
// have arrived, gives twice the median of the last window_size samples for each
// further sample. A row of cells keeps the window in sorted order, each cell
// tagged with its age; every accepted sample reorders all cells in a single update, so
// a sample is accepted on every clock while results are taken, and its result
// is loaded into the output register once that register is free. A stalled
// output holds back at most one more sample. Writing window_size
// (0 acts as 1, values above 64 act as 64) empties the window and filling starts
// again; write it only while no transaction is in flight. No clearing pass is
// needed after reset.
module sliding_window_median
  import swm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [CFG_BITS-1:0] window_size,
  input  logic                window_size_valid,
  output logic                window_size_ready,
  input  sample_t             sample,
  input  logic                sample_valid,
  output logic                sample_ready,
  output logic [OUT_BITS-1:0] median_x2,
  output logic                median_x2_valid,
  input  logic                median_x2_ready
);

  cnt_t                  k;
  cnt_t                  fill;
  sample_t               oldest;
  logic [WINDOW_MAX-1:0] sel_lo;
  logic [WINDOW_MAX-1:0] sel_hi;
  logic                  calc;

  cnt_t                  k_next;
  cnt_t                  cfg_raw;
  logic                  cfg_acc;
  logic                  in_acc;
  logic                  drain;
  logic                  full;
  logic                  due;
  cnt_t                  len;
  age_t                  age_match;
  sample_t               oldest_next;
  sample_t               lo_val;
  sample_t               hi_val;
  bcast_t                bc;

  cell_out_t cells [WINDOW_MAX];
  cell_ctl_t ctls  [WINDOW_MAX];

  function automatic logic [WINDOW_MAX-1:0] mid_sel(input cnt_t idx);
    logic [WINDOW_MAX-1:0] r;
    r = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      r[i] = (cnt_t'(i) == idx);
    end
    return r;
  endfunction

  assign window_size_ready = !rst;
  assign cfg_acc = window_size_valid && window_size_ready;

  always_comb begin
    cfg_raw = cnt_t'(window_size);
    if (cfg_raw == '0) begin
      k_next = cnt_t'(1);
    end else if (cfg_raw > cnt_t'(WINDOW_MAX)) begin
      k_next = cnt_t'(WINDOW_MAX);
    end else begin
      k_next = cfg_raw;
    end
  end

  assign full         = (fill == k);
  assign due          = full || ((fill + cnt_t'(1)) == k);
  assign len          = full ? (k - cnt_t'(1)) : fill;
  assign drain        = calc && (!median_x2_valid || median_x2_ready);
  assign sample_ready = !rst && (!calc || !median_x2_valid || median_x2_ready);
  assign in_acc       = sample_valid && sample_ready;

  assign bc.samp   = sample;
  assign bc.oldest = oldest;
  assign bc.full   = full;

  // Age of the sample that becomes the oldest once this transaction is done.
  assign age_match = AGE_BITS'(k - cnt_t'(2));

  always_comb begin
    oldest_next = '0;
    lo_val      = '0;
    hi_val      = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if ((cnt_t'(i) < fill) && (cells[i].age == age_match)) begin
        oldest_next = oldest_next | cells[i].val;
      end
      if (sel_lo[i]) begin
        lo_val = lo_val | cells[i].val;
      end
      if (sel_hi[i]) begin
        hi_val = hi_val | cells[i].val;
      end
    end
    if (k == cnt_t'(1)) begin
      oldest_next = sample;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    cell_out_t left_in;
    cell_out_t right_in;

    assign ctls[i].in_b  = cnt_t'(i) < len;
    assign ctls[i].first = (i == 0);
    if (i == 0) begin : g_first
      assign left_in       = '0;
      assign ctls[i].in_bp = 1'b0;
    end else begin : g_mid
      assign left_in       = cells[i-1];
      assign ctls[i].in_bp = cnt_t'(i - 1) < len;
    end
    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = cells[i+1];
    end

    swm_cell u_cell (
      .clk   (clk),
      .load  (in_acc),
      .bc    (bc),
      .ctl   (ctls[i]),
      .left  (left_in),
      .right (right_in),
      .own   (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k               <= cnt_t'(WS_RESET);
      fill            <= '0;
      sel_lo          <= mid_sel(cnt_t'((WS_RESET - 1) / 2));
      sel_hi          <= mid_sel(cnt_t'(WS_RESET / 2));
      calc            <= 1'b0;
      median_x2_valid <= 1'b0;
    end else begin
      if (cfg_acc) begin
        k      <= k_next;
        fill   <= '0;
        sel_lo <= mid_sel((k_next - cnt_t'(1)) >> 1);
        sel_hi <= mid_sel(k_next >> 1);
      end else if (in_acc && !full) begin
        fill <= fill + cnt_t'(1);
      end

      if (in_acc) begin
        calc <= due;
      end else if (drain) begin
        calc <= 1'b0;
      end

      if (drain) begin
        median_x2_valid <= 1'b1;
      end else if (median_x2_ready) begin
        median_x2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      oldest <= oldest_next;
    end
    if (drain) begin
      median_x2 <= {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/swm_cell.sv
// One cell of the sorted window: holds a sample and its age, and shifts with its neighbors.
`default_nettype none
module swm_cell
  import swm_pkg::*;
(
  input  logic      clk,
  input  logic      load,
  input  bcast_t    bc,
  input  cell_ctl_t ctl,
  input  cell_out_t left,
  input  cell_out_t right,
  output cell_out_t own
);

  sample_t val;
  age_t    age;
  sample_t val_next;
  age_t    age_next;

  logic    own_gt;
  logic    own_past;
  sample_t b_val;
  age_t    b_age;
  logic    b_big;
  sample_t lb_val;
  age_t    lb_age;
  logic    lb_big;

  always_comb begin
    own_gt   = val > bc.samp;
    own_past = bc.full && (val >= bc.oldest);

    // Slot content after the oldest sample is taken out of the list.
    b_val = own_past ? right.val : val;
    b_age = own_past ? right.age : age;
    b_big = !ctl.in_b || (own_past ? right.gt : own_gt);

    // The same view for the slot to the left.
    lb_val = left.past ? val : left.val;
    lb_age = left.past ? age : left.age;
    lb_big = !ctl.first && (!ctl.in_bp || (left.past ? own_gt : left.gt));

    if (lb_big) begin
      val_next = lb_val;
      age_next = lb_age + age_t'(1);
    end else if (b_big) begin
      val_next = bc.samp;
      age_next = '0;
    end else begin
      val_next = b_val;
      age_next = b_age + age_t'(1);
    end

    own.val  = val;
    own.age  = age;
    own.gt   = own_gt;
    own.past = own_past;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sliding window median filter.
module testbench;
  import swm_pkg::*;

  localparam int DRAIN = 8;

  typedef enum logic {ITEM_SAMPLE, ITEM_WINDOW} stim_kind_t;

  typedef struct {
    stim_kind_t  kind;
    logic [15:0] value;
  } stim_t;

  logic                clk;
  logic                rst = 1'b1;
  logic [CFG_BITS-1:0] window_size = '0;
  logic                window_size_valid = 1'b0;
  logic                window_size_ready;
  sample_t             sample = '0;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  logic [OUT_BITS-1:0] median_x2;
  logic                median_x2_valid;
  logic                median_x2_ready = 1'b0;

  sliding_window_median DUT (
    .clk               (clk),
    .rst               (rst),
    .window_size       (window_size),
    .window_size_valid (window_size_valid),
    .window_size_ready (window_size_ready),
    .sample            (sample),
    .sample_valid      (sample_valid),
    .sample_ready      (sample_ready),
    .median_x2         (median_x2),
    .median_x2_valid   (median_x2_valid),
    .median_x2_ready   (median_x2_ready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  stim_t               pending_q[$];
  logic [OUT_BITS-1:0] expected_medians[$];

  // Filter state as the predictor sees it.
  sample_t ring[WINDOW_MAX];
  sample_t ordered[WINDOW_MAX];
  int      held = 0;
  int      ring_head = 0;
  int      win_len = WS_RESET;

  int   errors = 0;
  int   samples_seen = 0;
  int   medians_checked = 0;
  int   windows_written = 0;
  int   win_lo = WS_RESET;
  int   win_hi = WS_RESET;
  int   since_sample = DRAIN;
  logic sample_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   gap_left = 0;
  int   calm_tx = 0;
  int   stall_left = 0;
  int   calm_rx = 0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 30) $display("tb: mismatch at %0t ns: %s", $time, what);
  endtask

  // Mostly short gaps, a few long ones, and now and then a long calm stretch.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void sorted_insert(input int n, input sample_t v);
    int i;
    i = n;
    while (i > 0 && ordered[i-1] > v) begin
      ordered[i] = ordered[i-1];
      i--;
    end
    ordered[i] = v;
  endfunction

  function automatic void set_window(input logic [CFG_BITS-1:0] v);
    if (v == 0) win_len = 1;
    else if (v > WINDOW_MAX) win_len = WINDOW_MAX;
    else win_len = int'(v);
    held = 0;
    ring_head = 0;
    if (win_len < win_lo) win_lo = win_len;
    if (win_len > win_hi) win_hi = win_len;
  endfunction

  // Moves the window by one sample and tells whether it yields a median.
  task automatic advance_window(input sample_t s, output bit gives,
                                output logic [OUT_BITS-1:0] m);
    int      k;
    int      p;
    int      i;
    sample_t leaving;
    k = win_len;
    gives = 1'b0;
    m = '0;
    if (held >= k) begin
      p = ring_head % k;
      leaving = ring[p];
      i = 0;
      while (i < k && ordered[i] != leaving) i++;
      while (i + 1 < k) begin
        ordered[i] = ordered[i+1];
        i++;
      end
      ring[p] = s;
      sorted_insert(k - 1, s);
      ring_head = (p + 1) % k;
      gives = 1'b1;
    end else begin
      ring[held] = s;
      sorted_insert(held, s);
      held++;
      ring_head = 0;
      gives = (held == k);
    end
    if (gives) m = OUT_BITS'(int'(ordered[(k-1)/2]) + int'(ordered[k/2]));
  endtask

  // Monitor: predicts on every accepted sample and checks every accepted median.
  always @(posedge clk) begin
    bit                  gives;
    logic [OUT_BITS-1:0] m;
    logic [OUT_BITS-1:0] want;
    if (rst) begin
      sample_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      sample_taken <= sample_valid && sample_ready;
      cfg_taken <= window_size_valid && window_size_ready;
      if (window_size_valid && window_size_ready) begin
        set_window(window_size);
        windows_written++;
      end
      if (sample_valid && sample_ready) begin
        advance_window(sample, gives, m);
        if (gives) expected_medians = {expected_medians, m};
        samples_seen++;
        since_sample <= 0;
      end else if (since_sample < DRAIN) begin
        since_sample <= since_sample + 1;
      end
      if (median_x2_valid && median_x2_ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("median %0d with none expected", $signed(median_x2)));
        end else begin
          want = expected_medians.pop_front();
          if (median_x2 !== want)
            report_mismatch($sformatf("median_x2 %0d, expected %0d",
                                      $signed(median_x2), $signed(want)));
          medians_checked++;
        end
      end
    end
  end

  // Driver: one transaction at a time; a window write waits until the filter is idle.
  always @(negedge clk) begin
    stim_t nxt;
    logic  sv;
    logic  cv;
    if (rst) begin
      sample_valid <= 1'b0;
      window_size_valid <= 1'b0;
    end else if (!((sample_valid && !sample_taken) ||
                   (window_size_valid && !cfg_taken))) begin
      sv = 1'b0;
      cv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() != 0) begin
        if (pending_q[0].kind == ITEM_WINDOW) begin
          if (expected_medians.size() == 0 && since_sample >= DRAIN) begin
            nxt = pending_q.pop_front();
            window_size <= nxt.value[CFG_BITS-1:0];
            cv = 1'b1;
          end
        end else begin
          nxt = pending_q.pop_front();
          sample <= sample_t'(nxt.value);
          sv = 1'b1;
        end
        if (sv || cv) gap_left = pick_gap(calm_tx);
      end
      sample_valid <= sv;
      window_size_valid <= cv;
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      median_x2_ready <= 1'b0;
      stall_left--;
    end else begin
      median_x2_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap(calm_rx);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  int queued = 0;

  task automatic add_sample(input int v);
    stim_t it;
    it.kind = ITEM_SAMPLE;
    it.value = v[15:0];
    pending_q = {pending_q, it};
    queued++;
  endtask

  task automatic add_window(input int v);
    stim_t it;
    it.kind = ITEM_WINDOW;
    it.value = {9'b0, v[6:0]};
    pending_q = {pending_q, it};
  endtask

  // Full-range values, small values that collide often, the extremes and mid-sized values.
  function automatic int pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 65535) - 32768;
    if (r < 7) return $urandom_range(0, 6) - 3;
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return -32768;
        1: return 32767;
        2: return -32767;
        default: return 32766;
      endcase
    end
    return $urandom_range(0, 400) - 200;
  endfunction

  initial begin
    int fixed_sizes[5];
    int sz;
    int eff;
    int r;
    fixed_sizes = '{127, 64, 65, 1, 2};
    for (int i = 0; i < WINDOW_MAX; i++) begin
      ring[i] = '0;
      ordered[i] = '0;
    end

    // Reset window of three: extremes, sign edges and repeated values.
    foreach (fixed_sizes[i]) begin end
    add_sample(32767);
    add_sample(-32768);
    add_sample(0);
    add_sample(-1);
    add_sample(1);
    add_sample(32767);
    add_sample(32767);
    add_sample(-32768);
    add_sample(-32768);
    add_sample(5);
    add_sample(5);
    add_sample(5);
    add_sample(-7);
    add_sample(100);
    add_sample(-100);
    // A written size of zero behaves as one.
    add_window(0);
    add_sample(32767);
    add_sample(-32768);
    add_sample(0);
    // An even window hits both ends of the output range.
    add_window(2);
    add_sample(32767);
    add_sample(32767);
    add_sample(-32768);
    add_sample(-32768);

    foreach (fixed_sizes[i]) begin
      add_window(fixed_sizes[i]);
      eff = (fixed_sizes[i] > WINDOW_MAX) ? WINDOW_MAX : fixed_sizes[i];
      repeat (eff + $urandom_range(10, 60)) add_sample(pick_sample());
    end
    while (queued < 1800) begin
      r = $urandom_range(0, 99);
      if (r < 70) sz = $urandom_range(1, 9);
      else if (r < 85) sz = $urandom_range(10, 64);
      else sz = $urandom_range(0, 127);
      add_window(sz);
      eff = (sz == 0) ? 1 : ((sz > WINDOW_MAX) ? WINDOW_MAX : sz);
      repeat (eff + $urandom_range(10, 60)) add_sample(pick_sample());
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || sample_valid || window_size_valid) @(posedge clk);
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("tb: %0d samples sent, %0d medians compared, %0d mismatches",
             samples_seen, medians_checked, errors);
    $display("tb: %0d window writes, effective sizes from %0d to %0d",
             windows_written, win_lo, win_hi);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
